// File: src/rnvs_pkg.sv
// ----------------------------------------------------------------------------
// rnvs_pkg: shared types, constants and saturating helpers
// Widths of the price and result fields, the controller state and command
// types, and 64-bit saturating arithmetic used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rnvs_pkg;

   localparam int DEF_MAX_WINDOW = 256;
   localparam int RESET_WINDOW   = 16;
   localparam int MIN_WINDOW     = 3;
   localparam int PRICE_W        = 32;
   localparam int VAR_W          = 64;
   localparam int SNR_W          = 32;
   localparam int CSR_W          = 9;
   localparam int RET_W          = 28;
   localparam int FRAC_W         = 16;
   localparam int NUM_W          = VAR_W + FRAC_W;
   localparam int DIV_CNT_W      = $clog2(NUM_W);

   localparam logic signed [VAR_W-1:0] VAR_MAX = {1'b0, {(VAR_W-1){1'b1}}};
   localparam logic signed [VAR_W-1:0] VAR_MIN = {1'b1, {(VAR_W-1){1'b0}}};
   localparam logic signed [SNR_W-1:0] SNR_MAX = {1'b0, {(SNR_W-1){1'b1}}};
   localparam logic signed [SNR_W-1:0] SNR_MIN = {1'b1, {(SNR_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_LAG_GO,
      ST_LAG_WAIT,
      ST_COMB1,
      ST_COMB2,
      ST_COMB3,
      ST_COMB4,
      ST_SNR_GO,
      ST_SNR_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_SUMSQ,
      DIV_LAG,
      DIV_SNR
   } div_op_type;

   typedef struct packed {
      logic       cfg_write;
      logic       load_item;
      logic       scan_en;
      logic       div_start;
      div_op_type div_op;
      logic       comb1;
      logic       comb2;
      logic       comb3;
      logic       comb4;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_last;
      logic div_done;
      logic den_zero;
      logic out_free;
   } stat_type;

   function automatic logic signed [VAR_W-1:0] sat_add64(
      input logic signed [VAR_W-1:0] a,
      input logic signed [VAR_W-1:0] b);
      logic [VAR_W:0] s;
      s = {a[VAR_W-1], a} + {b[VAR_W-1], b};
      if (s[VAR_W] != s[VAR_W-1]) begin
         sat_add64 = s[VAR_W] ? VAR_MIN : VAR_MAX;
      end else begin
         sat_add64 = s[VAR_W-1:0];
      end
   endfunction

   function automatic logic signed [VAR_W-1:0] sat_sub64(
      input logic signed [VAR_W-1:0] a,
      input logic signed [VAR_W-1:0] b);
      logic [VAR_W:0] s;
      s = {a[VAR_W-1], a} - {b[VAR_W-1], b};
      if (s[VAR_W] != s[VAR_W-1]) begin
         sat_sub64 = s[VAR_W] ? VAR_MIN : VAR_MAX;
      end else begin
         sat_sub64 = s[VAR_W-1:0];
      end
   endfunction

   function automatic logic [VAR_W-1:0] mag64(input logic signed [VAR_W-1:0] a);
      mag64 = a[VAR_W-1] ? (~a + 1'b1) : a;
   endfunction

   function automatic logic signed [VAR_W-1:0] from_mag64(
      input logic             neg,
      input logic [VAR_W-1:0] m);
      if (!neg) begin
         from_mag64 = m[VAR_W-1] ? VAR_MAX : m;
      end else if (m[VAR_W-1]) begin
         from_mag64 = VAR_MIN;
      end else begin
         from_mag64 = ~m + 1'b1;
      end
   endfunction

endpackage

`default_nettype wire

// File: src/rnvs_ram.sv
// ----------------------------------------------------------------------------
// rnvs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rnvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// File: src/rnvs_div.sv
// ----------------------------------------------------------------------------
// rnvs_div: serial restoring divider
// Unsigned 80-bit dividend over 64-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rnvs_div import rnvs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [VAR_W-1:0] dvs,
   output logic                  done,
   output logic      [NUM_W-1:0] quo
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAR_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [VAR_W-1:0]     dvs_ff, dvs_in;
   logic [VAR_W:0]       rem_sh;
   logic [VAR_W:0]       rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign ge      = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         dvs_in  = dvs;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[VAR_W-1:0] : rem_sh[VAR_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// File: src/rnvs_dp.sv
// ----------------------------------------------------------------------------
// rnvs_dp: datapath
// Price history, window scan with return and product pipeline, running sums,
// shared divider, result combination and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rnvs_dp import rnvs_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic signed [PRICE_W-1:0] req_price,
   input  wire logic        [CSR_W-1:0]   csr_window_length,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_valid_res,
   output logic signed [VAR_W-1:0]      rsp_realized_variance,
   output logic signed [VAR_W-1:0]      rsp_noise_variance,
   output logic signed [SNR_W-1:0]      rsp_signal_to_noise
);

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int CW = $clog2(MAX_WINDOW + 3);
   localparam logic [WW-1:0] RST_WIN =
      WW'((RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW);
   localparam logic signed [PRICE_W:0] RET_HI = (PRICE_W+1)'((1 << (RET_W-1)) - 1);
   localparam logic signed [PRICE_W:0] RET_LO = -(PRICE_W+1)'(1 << (RET_W-1));

   logic [WW-1:0]               win_ff, win_in;
   logic [WW-1:0]               fill_ff;
   logic [AW-1:0]               wp_ff;
   logic [AW-1:0]               rd_ptr_ff;
   logic [CW-1:0]               cnt_ff;
   logic                        live_ff;
   logic                        r_v_ff, p_v_ff, lagok_ff, lagok_p_ff;
   logic                        rsp_valid_ff;
   logic signed [PRICE_W-1:0]   price_ff, prev_price_ff;
   logic signed [RET_W-1:0]     r_ff, pr_ff, r_in;
   logic signed [2*RET_W-1:0]   sq_ff, lp_ff, sq_prod, lp_prod;
   logic signed [VAR_W-1:0]     sumsq_ff, lag_ff, a_ff, g_ff, noise_ff, t_ff;
   logic signed [VAR_W-1:0]     s1_ff, den_ff, sig_ff, s2;
   logic signed [PRICE_W:0]     diff;
   logic [PRICE_W-1:0]          ram_q;
   logic                        stage1, first;
   logic [NUM_W-1:0]            div_num, div_q;
   logic [VAR_W-1:0]            div_dvs;
   logic                        div_done;
   logic                        over;
   logic signed [SNR_W-1:0]     snr_q;

   // window register clamp
   always_comb begin
      if (csr_window_length < CSR_W'(MIN_WINDOW)) begin
         win_in = WW'(MIN_WINDOW);
      end else if (32'(csr_window_length) > MAX_WINDOW) begin
         win_in = WW'(MAX_WINDOW);
      end else begin
         win_in = WW'(csr_window_length);
      end
   end

   rnvs_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (MAX_WINDOW)
   ) u_hist (
      .clock (clock),
      .we    (cmd.out_load),
      .waddr (wp_ff),
      .wdata (price_ff),
      .raddr (rd_ptr_ff),
      .rdata (ram_q)
   );

   // scan stage 1: ram data for index cnt-1
   assign stage1 = cmd.scan_en && (cnt_ff != '0) && (cnt_ff <= CW'(win_ff));
   assign first  = (cnt_ff == CW'(1));
   assign diff   = $signed({ram_q[PRICE_W-1], ram_q})
                 - $signed({prev_price_ff[PRICE_W-1], prev_price_ff});

   always_comb begin
      if (diff > RET_HI) begin
         r_in = RET_HI[RET_W-1:0];
      end else if (diff < RET_LO) begin
         r_in = RET_LO[RET_W-1:0];
      end else begin
         r_in = diff[RET_W-1:0];
      end
   end

   assign sq_prod = r_ff * r_ff;
   assign lp_prod = r_ff * pr_ff;

   // divider operand select
   always_comb begin
      div_num = '0;
      div_dvs = '0;
      case (cmd.div_op)
         DIV_SUMSQ: begin
            div_num = {{FRAC_W{1'b0}}, mag64(sumsq_ff)};
            div_dvs = VAR_W'(win_ff);
         end
         DIV_LAG: begin
            div_num = {{FRAC_W{1'b0}}, mag64(lag_ff)};
            div_dvs = VAR_W'(win_ff - WW'(2));
         end
         DIV_SNR: begin
            div_num = {sig_ff, {FRAC_W{1'b0}}};
            div_dvs = mag64(den_ff);
         end
         default: begin
            div_num = '0;
            div_dvs = '0;
         end
      endcase
   end

   rnvs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .dvs   (div_dvs),
      .done  (div_done),
      .quo   (div_q)
   );

   assign s2    = sat_sub64(s1_ff, noise_ff);
   assign over  = |div_q[NUM_W-1:SNR_W-1];
   assign snr_q = den_ff[VAR_W-1] ? (over ? SNR_MIN : -$signed(div_q[SNR_W-1:0]))
                                  : (over ? SNR_MAX : $signed(div_q[SNR_W-1:0]));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= RST_WIN;
         fill_ff      <= '0;
         wp_ff        <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         live_ff      <= 1'b0;
         r_v_ff       <= 1'b0;
         p_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_write) begin
            win_ff    <= win_in;
            fill_ff   <= '0;
            wp_ff     <= '0;
            rd_ptr_ff <= '0;
         end
         if (cmd.load_item) begin
            rd_ptr_ff <= wp_ff;
            cnt_ff    <= '0;
            live_ff   <= stat.full;
         end else if (cmd.scan_en) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff < CW'(win_ff)) begin
               rd_ptr_ff <= (WW'(rd_ptr_ff) + 1'b1 == win_ff) ? '0 : rd_ptr_ff + 1'b1;
            end
         end
         r_v_ff <= stage1 && !first;
         p_v_ff <= r_v_ff;
         if (cmd.out_load) begin
            wp_ff <= (WW'(wp_ff) + 1'b1 == win_ff) ? '0 : wp_ff + 1'b1;
            if (fill_ff < win_ff) begin
               fill_ff <= fill_ff + 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         price_ff <= req_price;
         sumsq_ff <= '0;
         lag_ff   <= '0;
      end
      if (stage1) begin
         prev_price_ff <= $signed(ram_q);
         lagok_ff      <= (cnt_ff >= CW'(3));
         if (!first) begin
            r_ff <= r_in;
         end
      end
      if (r_v_ff) begin
         sq_ff      <= sq_prod;
         lp_ff      <= lagok_ff ? lp_prod : '0;
         lagok_p_ff <= lagok_ff;
         pr_ff      <= r_ff;
      end
      if (p_v_ff) begin
         sumsq_ff <= sat_add64(sumsq_ff, VAR_W'(sq_ff));
         lag_ff   <= sat_add64(lag_ff, VAR_W'(lp_ff));
      end
      if (div_done && cmd.div_op == DIV_SUMSQ) begin
         a_ff <= from_mag64(sumsq_ff[VAR_W-1], div_q[VAR_W-1:0]);
      end
      if (div_done && cmd.div_op == DIV_LAG) begin
         g_ff <= from_mag64(lag_ff[VAR_W-1], div_q[VAR_W-1:0]);
      end
      if (cmd.comb1) begin
         noise_ff <= (g_ff == VAR_MIN) ? VAR_MAX : -g_ff;
         t_ff     <= sat_add64(a_ff, g_ff);
      end else if (cmd.comb2) begin
         t_ff <= sat_add64(t_ff, g_ff);
      end
      if (cmd.comb3) begin
         s1_ff  <= sat_sub64(t_ff, noise_ff);
         den_ff <= sat_add64(noise_ff, VAR_W'(1));
      end
      if (cmd.comb4) begin
         sig_ff <= s2[VAR_W-1] ? '0 : s2;
      end
      if (cmd.out_load) begin
         rsp_valid_res         <= 1'b0;
         rsp_realized_variance <= '0;
         rsp_noise_variance    <= '0;
         rsp_signal_to_noise   <= '0;
         if (live_ff) begin
            if (den_ff != '0) begin
               rsp_valid_res         <= 1'b1;
               rsp_realized_variance <= t_ff;
               rsp_noise_variance    <= noise_ff;
               rsp_signal_to_noise   <= snr_q;
            end else if (sig_ff != '0) begin
               rsp_valid_res         <= 1'b1;
               rsp_realized_variance <= t_ff;
               rsp_noise_variance    <= noise_ff;
               rsp_signal_to_noise   <= SNR_MAX;
            end
         end
      end
   end

   assign stat.full      = (fill_ff >= win_ff);
   assign stat.scan_last = cmd.scan_en && (cnt_ff == CW'(win_ff) + CW'(2));
   assign stat.div_done  = div_done;
   assign stat.den_zero  = (den_ff == '0);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;

   // lag product of the first return is never accumulated
   a_lag_first: assert property (@(posedge clock) disable iff (reset)
      p_v_ff && !lagok_p_ff |-> lp_ff == '0)
      else $error("lag product present for first return");

   a_scan_ptr: assert property (@(posedge clock) disable iff (reset)
      WW'(rd_ptr_ff) < win_ff && WW'(wp_ff) < win_ff)
      else $error("history pointer beyond window");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_ff)
      else $error("fill count beyond window");

endmodule

`default_nettype wire

// File: src/rnvs_ctrl.sv
// ----------------------------------------------------------------------------
// rnvs_ctrl: sequencing state machine
// Steps one item through scan, up to three divisions and the result combination,
// or straight to the output while the window is still filling.
`default_nettype none

module rnvs_ctrl import rnvs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic     csr_valid,
   output logic          csr_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) begin
               state_in = stat.full ? ST_SCAN : ST_OUT;
            end
         end
         ST_SCAN:     if (stat.scan_last) state_in = ST_SQ_GO;
         ST_SQ_GO:    state_in = ST_SQ_WAIT;
         ST_SQ_WAIT:  if (stat.div_done) state_in = ST_LAG_GO;
         ST_LAG_GO:   state_in = ST_LAG_WAIT;
         ST_LAG_WAIT: if (stat.div_done) state_in = ST_COMB1;
         ST_COMB1:    state_in = ST_COMB2;
         ST_COMB2:    state_in = ST_COMB3;
         ST_COMB3:    state_in = ST_COMB4;
         ST_COMB4:    state_in = stat.den_zero ? ST_OUT : ST_SNR_GO;
         ST_SNR_GO:   state_in = ST_SNR_WAIT;
         ST_SNR_WAIT: if (stat.div_done) state_in = ST_OUT;
         ST_OUT:      if (stat.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_ready     = 1'b1;
            req_ready     = !csr_valid;
            cmd.cfg_write = csr_valid;
            cmd.load_item = req_valid && !csr_valid;
         end
         ST_SCAN: cmd.scan_en = 1'b1;
         ST_SQ_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_SUMSQ;
         end
         ST_SQ_WAIT: cmd.div_op = DIV_SUMSQ;
         ST_LAG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_LAG;
         end
         ST_LAG_WAIT: cmd.div_op = DIV_LAG;
         ST_COMB1:    cmd.comb1 = 1'b1;
         ST_COMB2:    cmd.comb2 = 1'b1;
         ST_COMB3:    cmd.comb3 = 1'b1;
         ST_COMB4:    cmd.comb4 = 1'b1;
         ST_SNR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_SNR;
         end
         ST_SNR_WAIT: cmd.div_op = DIV_SNR;
         ST_OUT:      cmd.out_load = stat.out_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/rolling_noise_robust_variance_snr_top.sv
// ----------------------------------------------------------------------------
// rolling_noise_robust_variance_snr_top: rolling noise-robust variance and SNR
// Realized variance with lag-1 autocovariance correction over a price window.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one signed Q16.16 price. Before
// the price enters the window, the block scans the W prices already held
// (W = window register, clamped to 3..MAX_WINDOW), oldest first, and forms
// the squared-return and lag-1 product sums of their returns (each return
// saturated to 28 bits). It then produces one rsp_ transfer: realized
// variance and noise variance in Q32.32 and signal-to-noise in Q16.16, all
// saturating. Until W prices have been seen since reset or the last csr_
// write, valid_res is 0 and the other fields are 0; a 0/0 ratio also gives
// valid_res 0. Once the window is full, an item streams the history memory
// through its single read port and the return/product pipeline, then makes
// three passes of one shared bit-serial divider (80 quotient bits each) for
// sum/W, lag/(W-2) and the ratio. When noise + eps is zero the ratio pass
// is skipped. While the window is still filling, an item skips the scan and
// the divisions. A stalled rsp_ channel holds the item in the hand-over
// state. The next price is taken while a finished result still waits in the
// output register.
// Writing csr_window_length restarts filling; write it only while the block
// is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_noise_robust_variance_snr_top import rnvs_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [PRICE_W-1:0] req_price,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid_res,
   output logic signed [VAR_W-1:0]        rsp_realized_variance,
   output logic signed [VAR_W-1:0]        rsp_noise_variance,
   output logic signed [SNR_W-1:0]        rsp_signal_to_noise,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_W-1:0]          csr_window_length
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: accept, scan, divide, combine, hand over
   rnvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // history memory, sums, divider and output register
   rnvs_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_price             (req_price),
      .csr_window_length     (csr_window_length),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_valid_res         (rsp_valid_res),
      .rsp_realized_variance (rsp_realized_variance),
      .rsp_noise_variance    (rsp_noise_variance),
      .rsp_signal_to_noise   (rsp_signal_to_noise)
   );

   // an invalid result carries all-zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_realized_variance == '0
         && rsp_noise_variance == '0 && rsp_signal_to_noise == '0)
      else $error("invalid result with nonzero fields");

   // a negative ratio only comes from a negative noise estimate
   a_snr_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res && rsp_signal_to_noise[SNR_W-1]
         |-> rsp_noise_variance[VAR_W-1])
      else $error("negative ratio with non-negative noise");

   // hold off further prices while one is in work
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !csr_ready)
      else $error("second transfer taken while busy");

endmodule

`default_nettype wire
